// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the core files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/core/lfuc_pkg.sv
package lfuc_pkg;
	localparam int ENTRIES = 16;
	localparam int COUNT_BITS = 16;
	localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_BITS = $clog2(ENTRIES + 1);
	localparam int CAP_BITS = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_DONE
	} lfuc_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clear_scan;
		logic scan_step;
		logic apply;
	} lfuc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} lfuc_sts_t;
endpackage

// File: rtl/core/lfuc_ctrl.sv
module lfuc_ctrl
	import lfuc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  lfuc_sts_t  sts,
	output lfuc_cmd_t  cmd
);
	`include "assert_macros.svh"

	lfuc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SCAN;
			ST_SCAN:  if (sts.scan_last) state_d = ST_APPLY;
			ST_APPLY: state_d = ST_DONE;
			ST_DONE:  if (!out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
				cmd.clear_scan = in_valid;
			end
			ST_SCAN:  cmd.scan_step = 1'b1;
			ST_APPLY: cmd.apply = 1'b1;
			ST_DONE:  out_valid = 1'b1;
			default: ;
		endcase
	end

	`ASSERT_IMPL(a_load_starts_scan, clk, arst_n, cmd.load |=> (state_q == ST_SCAN), "load without scan")
	`ASSERT_IMPL(a_apply_then_done, clk, arst_n, cmd.apply |=> out_valid, "apply without result")
	`ASSERT_NEVER(a_no_take_busy, clk, arst_n, !in_stall && out_valid, "input taken while result held")
endmodule

// File: rtl/core/lfuc_dp.sv
module lfuc_dp
	import lfuc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CAP_BITS-1:0] cfg_data,
	input  logic                kind,
	input  logic signed [31:0]  lookup_key,
	input  logic signed [31:0]  put_value,
	input  lfuc_cmd_t           cmd,
	output lfuc_sts_t           sts,
	output logic                hit,
	output logic signed [31:0]  read_value,
	output logic                evicted,
	output logic signed [31:0]  evicted_key
);
	`include "assert_macros.svh"

	logic [CAP_BITS-1:0]   cap_q;
	logic [ENTRIES-1:0]    valid_q;
	logic [31:0]           key_q   [ENTRIES];
	logic [31:0]           val_q   [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_q   [ENTRIES];
	logic [IDX_BITS-1:0]   rank_q  [ENTRIES];
	logic [OCC_BITS-1:0]   occ_q;

	logic                  kind_q;
	logic [31:0]           rkey_q, rval_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic                  found_q, vic_ok_q, free_ok_q;
	logic [IDX_BITS-1:0]   found_idx_q, vic_idx_q, free_idx_q;
	logic [COUNT_BITS-1:0] vic_cnt_q;
	logic [IDX_BITS-1:0]   vic_rank_q;

	// per-entry flags sampled in the scan cycle, one entry at a time
	logic                  e_valid, e_match, e_better;
	logic [COUNT_BITS-1:0] e_cnt;
	logic [IDX_BITS-1:0]   e_rank;

	assign e_valid = valid_q[idx_q];
	assign e_match = e_valid && (key_q[idx_q] == rkey_q);
	assign e_cnt = cnt_q[idx_q];
	assign e_rank = rank_q[idx_q];
	assign e_better = e_valid && (!vic_ok_q || (e_cnt < vic_cnt_q) ||
		((e_cnt == vic_cnt_q) && (e_rank > vic_rank_q)));
	assign sts.scan_last = (idx_q == IDX_BITS'(ENTRIES - 1));

	logic [OCC_BITS-1:0] limit;
	always_comb begin
		if (cap_q == '0) limit = OCC_BITS'(1);
		else if (32'(cap_q) > 32'(ENTRIES)) limit = OCC_BITS'(ENTRIES);
		else limit = OCC_BITS'(cap_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= CAP_RESET;
		else if (cfg_we) cap_q <= cfg_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			rkey_q <= lookup_key;
			rval_q <= put_value;
		end
	end

	// scan sequencer: one entry per cycle for match, victim and free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			found_q <= 1'b0;
			vic_ok_q <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (cmd.clear_scan) begin
			idx_q <= '0;
			found_q <= 1'b0;
			vic_ok_q <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (!sts.scan_last) idx_q <= idx_q + 1'b1;
			if (e_match && !found_q) found_q <= 1'b1;
			if (e_better) vic_ok_q <= 1'b1;
			if (!e_valid && !free_ok_q) free_ok_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			if (e_match && !found_q) found_idx_q <= idx_q;
			if (e_better) begin
				vic_idx_q <= idx_q;
				vic_cnt_q <= e_cnt;
				vic_rank_q <= e_rank;
			end
			if (!e_valid && !free_ok_q) free_idx_q <= idx_q;
		end
	end

	// write-back: apply the request to the store in the apply state
	logic                do_evict, do_ins;
	logic [IDX_BITS-1:0] slot;
	assign do_evict = !found_q && (kind_q == KIND_PUT) && (occ_q >= limit) && vic_ok_q;
	assign do_ins = !found_q && (kind_q == KIND_PUT) && (do_evict || free_ok_q);
	assign slot = do_evict ? vic_idx_q : free_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q <= '0;
			for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
		end else if (cmd.apply) begin
			if (found_q) begin
				for (int i = 0; i < ENTRIES; i++)
					if (valid_q[i] && IDX_BITS'(i) != found_idx_q &&
						rank_q[i] < rank_q[found_idx_q])
						rank_q[i] <= rank_q[i] + 1'b1;
				rank_q[found_idx_q] <= '0;
			end else if (do_ins) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && IDX_BITS'(i) != slot) begin
						if (do_evict && rank_q[i] > vic_rank_q) rank_q[i] <= rank_q[i];
						else rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
				rank_q[slot] <= '0;
				valid_q[slot] <= 1'b1;
				if (!do_evict) occ_q <= occ_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			if (found_q) begin
				if (kind_q == KIND_PUT) val_q[found_idx_q] <= rval_q;
				if (cnt_q[found_idx_q] != COUNT_MAX)
					cnt_q[found_idx_q] <= cnt_q[found_idx_q] + 1'b1;
			end else if (do_ins) begin
				key_q[slot] <= rkey_q;
				val_q[slot] <= rval_q;
				cnt_q[slot] <= COUNT_BITS'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			hit <= found_q;
			read_value <= (found_q && kind_q == KIND_GET) ? val_q[found_idx_q] : WORD_ONES;
			evicted <= do_evict;
			evicted_key <= do_evict ? key_q[vic_idx_q] : 32'd0;
		end
	end

	`ASSERT_IMPL(a_occ_bound, clk, arst_n, 1'b1 |-> (32'(occ_q) <= 32'(ENTRIES)), "occupancy overflow")
	`ASSERT_IMPL(a_occ_count, clk, arst_n, 1'b1 |-> (32'(occ_q) == 32'($countones(valid_q))), "occupancy mismatch")
	`ASSERT_NEVER(a_evict_hit, clk, arst_n, cmd.apply && found_q && do_evict, "eviction on hit")
endmodule

// File: rtl/core/lfu_cache_lru_tiebreak_core.sv
// LFU key-value cache with LRU tie-break, sixteen entries. Each request
// (get or put) is taken when in_valid is high and in_stall low; one result
// follows. A request passes through an idle state in which it is latched, a
// scan in which the sequencer walks the entries one per cycle looking for the
// key, the least used and least recent victim and the first free slot, a
// write-back state that updates counts, ranks and the store and loads the
// result register, and a done state in which the result is presented until
// out_stall is low. The next request is taken in the cycle after the result
// has been delivered. capacity_in_use may be written only while idle; 0 acts
// as 1 and values above sixteen act as sixteen.
module lfu_cache_lru_tiebreak_core
	import lfuc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [4:0]          capacity_in_use,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic signed [31:0]  lookup_key,
	input  logic signed [31:0]  put_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit,
	output logic signed [31:0]  read_value,
	output logic                evicted,
	output logic signed [31:0]  evicted_key
);
	lfuc_cmd_t cmd;
	lfuc_sts_t sts;

	// sequencer: idle, scan, write back, hold the result
	lfuc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.sts, .cmd
	);

	// entry store, scan registers and result register
	lfuc_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_data(capacity_in_use),
		.kind, .lookup_key, .put_value, .cmd, .sts,
		.hit, .read_value, .evicted, .evicted_key
	);
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import lfuc_pkg::*;

	localparam int N = 16;

	typedef struct packed {
		logic        kind;
		logic [31:0] key;
		logic [31:0] val;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] rd;
		logic        ev;
		logic [31:0] ekey;
	} resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [4:0] cfg_cap = 5'd16;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = KIND_GET;
	logic signed [31:0] lookup_key = '0;
	logic signed [31:0] put_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic signed [31:0] read_value;
	logic evicted;
	logic signed [31:0] evicted_key;

	lfu_cache_lru_tiebreak_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .capacity_in_use(cfg_cap),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind),
		.lookup_key(lookup_key), .put_value(put_value),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit),
		.read_value(read_value), .evicted(evicted), .evicted_key(evicted_key)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the cache, advanced once per accepted request
	logic [4:0]  sh_cap;
	logic        sh_valid [N];
	logic [31:0] sh_key   [N];
	logic [31:0] sh_val   [N];
	logic [15:0] sh_count [N];
	logic [3:0]  sh_rank  [N];
	int          sh_occ;

	req_t  pending_reqs[$];
	resp_t expected_resps[$];
	int    errors = 0;
	int    sent = 0;
	bit    calm = 1'b0;     // no idling in the closing stretch
	logic [31:0] key_pool[$];

	// Bring entry e to the front; fresher entries age by one
	function automatic void promote(int e);
		for (int i = 0; i < N; i++)
			if (sh_valid[i] && i != e && sh_rank[i] < sh_rank[e])
				sh_rank[i]++;
		sh_rank[e] = 0;
	endfunction

	function automatic resp_t cache_access(req_t r);
		resp_t o;
		int found;
		int slot;
		int lim;
		found = -1;
		slot = -1;
		o = '{hit: 1'b0, rd: WORD_ONES, ev: 1'b0, ekey: 32'd0};
		for (int i = 0; i < N && found < 0; i++)
			if (sh_valid[i] && sh_key[i] == r.key)
				found = i;
		if (found >= 0) begin
			o.hit = 1'b1;
			if (r.kind == KIND_GET)
				o.rd = sh_val[found];
			else
				sh_val[found] = r.val;
			if (sh_count[found] != COUNT_MAX)
				sh_count[found]++;
			promote(found);
		end else if (r.kind == KIND_PUT) begin
			lim = (sh_cap == 0) ? 1 : (sh_cap > N ? N : sh_cap);
			if (sh_occ >= lim) begin
				// least used, oldest on a tie
				for (int i = 0; i < N; i++) begin
					if (!sh_valid[i])
						continue;
					if (slot < 0 || sh_count[i] < sh_count[slot] ||
					    (sh_count[i] == sh_count[slot] && sh_rank[i] > sh_rank[slot]))
						slot = i;
				end
				if (slot >= 0) begin
					o.ev = 1'b1;
					o.ekey = sh_key[slot];
					sh_valid[slot] = 1'b0;
					for (int i = 0; i < N; i++)
						if (sh_valid[i] && sh_rank[i] > sh_rank[slot])
							sh_rank[i]--;
					sh_occ--;
				end
			end
			for (int i = 0; i < N && slot < 0; i++)
				if (!sh_valid[i])
					slot = i;
			for (int i = 0; i < N; i++)
				if (sh_valid[i])
					sh_rank[i]++;
			sh_valid[slot] = 1'b1;
			sh_key[slot] = r.key;
			sh_val[slot] = r.val;
			sh_count[slot] = 16'd1;
			sh_rank[slot] = 0;
			sh_occ++;
		end
		return o;
	endfunction

	// Keys mostly come from a small pool so that hits and evictions are common
	function automatic req_t rand_req();
		req_t r;
		r.kind = $urandom_range(0, 1);
		r.val = $urandom;
		if ($urandom_range(0, 9) < 8 && key_pool.size() > 0)
			r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
		else
			r.key = $urandom;
		return r;
	endfunction

	// Driver: hold the request while stalled, advance on acceptance
	int in_gap = 0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_resps.push_back(cache_access('{kind, lookup_key, put_value}));
			sent++;
		end
		if (!in_valid || !in_stall) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				in_gap <= $urandom_range(0, 17);
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0 && arst_n) begin
				req_t r;
				r = pending_reqs.pop_front();
				in_valid <= 1'b1;
				kind <= r.kind;
				lookup_key <= r.key;
				put_value <= r.val;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each delivered response with the oldest prediction
	int out_gap = 0;
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_resps.size() == 0) begin
				$error("unexpected response");
				errors++;
			end else begin
				resp_t e;
				e = expected_resps.pop_front();
				if (hit !== e.hit) begin
					$error("hit exp %0h got %0h", e.hit, hit); errors++;
				end
				if (read_value !== e.rd) begin
					$error("read_value exp %0h got %0h", e.rd, read_value); errors++;
				end
				if (evicted !== e.ev) begin
					$error("evicted exp %0h got %0h", e.ev, evicted); errors++;
				end
				if (evicted_key !== e.ekey) begin
					$error("evicted_key exp %0h got %0h", e.ekey, evicted_key); errors++;
				end
			end
		end
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			out_gap <= $urandom_range(0, 17);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Wait for every queued request to be taken and answered; look between
	// edges so that the driver and monitor have settled
	task automatic drain();
		@(negedge clk);
		while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
			@(negedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic set_capacity(logic [4:0] c);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_cap <= c;
		sh_cap = c;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push(logic k, logic [31:0] key, logic [31:0] v);
		pending_reqs.push_back('{k, key, v});
	endtask

	initial begin
		logic [4:0] caps[6];
		int pool_n;
		caps = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd7};
		sh_cap = 5'd16;
		sh_occ = 0;
		for (int i = 0; i < N; i++) begin
			sh_valid[i] = 1'b0; sh_key[i] = '0; sh_val[i] = '0;
			sh_count[i] = '0; sh_rank[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: misses, extreme keys and values, updates, LFU and LRU ties
		push(KIND_GET, 32'h8000_0000, 32'h0);
		push(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		push(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		push(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push(KIND_PUT, 32'h0, 32'h0);
		push(KIND_GET, 32'h8000_0000, 32'h1234);
		push(KIND_GET, 32'h7FFF_FFFF, 32'h0);
		push(KIND_PUT, 32'h0, 32'h5555_AAAA);
		push(KIND_GET, 32'h0, 32'h0);
		push(KIND_GET, 32'hFFFF_FFFF, 32'h0);
		drain();
		// Shrink below occupancy: each new put evicts
		set_capacity(5'd2);
		push(KIND_PUT, 32'h11, 32'h1);
		push(KIND_PUT, 32'h22, 32'h2);
		push(KIND_GET, 32'h11, 32'h0);
		push(KIND_PUT, 32'h33, 32'h3);
		push(KIND_GET, 32'h22, 32'h0);
		drain();
		set_capacity(5'd0);
		push(KIND_PUT, 32'h44, 32'h4);
		push(KIND_PUT, 32'h55, 32'h5);
		push(KIND_GET, 32'h44, 32'h0);
		drain();

		// Random phases across capacity settings
		for (int p = 0; p < 6; p++) begin
			set_capacity(caps[p]);
			key_pool.delete();
			pool_n = $urandom_range(3, 24);
			for (int k = 0; k < pool_n; k++)
				key_pool.push_back($urandom);
			for (int i = 0; i < 165; i++)
				pending_reqs.push_back(rand_req());
			// Hot key hammered so its count climbs
			if (p == 4)
				for (int i = 0; i < 40; i++)
					push(KIND_GET, key_pool[0], 32'h0);
			drain();
		end
		calm = 1'b1;
		for (int i = 0; i < 60; i++)
			pending_reqs.push_back(rand_req());
		drain();

		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_top: done, errors");
		$finish;
	end
endmodule
